>>> rtl/core/pse_pkg.sv
// Shared types and constants for the printable string extractor.
// No dependencies; used by pse_cell and printable_string_extractor.
package pse_pkg;

   localparam int BufferSizeDefault = 64;
   localparam int RunDepth          = 63;

   localparam logic [1:0] CSR_MIN_LENGTH    = 2'd0;
   localparam logic [1:0] CSR_START_OFFSET  = 2'd1;
   localparam logic [1:0] CSR_SCAN_LIMIT    = 2'd2;
   localparam logic [1:0] CSR_OFFSET_ENABLE = 2'd3;

   localparam logic [7:0] CHAR_NUL     = 8'h00;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_DEL     = 8'h7F;

   typedef enum logic {
      PSE_IDLE,
      PSE_DRAIN
   } pse_state_type;

   typedef struct packed {
      logic       append;
      logic       restart;
      logic       drop;
      logic       shift;
      logic [6:0] ch;
   } pse_ctrl_type;

endpackage

>>> rtl/core/printable_string_extractor.sv
// Top level of the printable string extractor: controller, config registers, cell chain.
// Depends on pse_pkg and pse_cell.
//
//   channel | ports   | direction | content
//   req     | req_t*  | in        | tdata: data_byte[7:0]; tuser: new_file
//   rsp     | rsp_t*  | out       | tdata: text_char[6:0], run_offset[38:7]; tlast: run_last
//   csr     | csr_*   | in        | index 0..3, 32-bit write data
//
// Input bytes are taken one per cycle while idle; an emitted run is then shifted out of the cell
// chain head, one character per cycle while rsp is ready; no byte is taken meanwhile.
// Reset is synchronous and clears control state; the cell chain needs no clearing pass.
// A stalled rsp side holds the chain and the current character.
module printable_string_extractor #(
   parameter int BUFFER_SIZE = pse_pkg::BufferSizeDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // new_file
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // text_char[6:0], run_offset[38:7], zero[39]
   output logic        rsp_tlast,   // run_last
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import pse_pkg::*;

   localparam int Cap = (BUFFER_SIZE - 1 > RunDepth) ? RunDepth : BUFFER_SIZE - 1;
   localparam int FW  = $clog2(Cap + 1);

   pse_state_type state_ff, state_in;

   logic [5:0]    min_length_ff;
   logic [31:0]   start_offset_ff, scan_limit_ff;
   logic          offset_enable_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [31:0]   consumed_ff, consumed_in;
   logic [31:0]   run_start_ff, run_start_in;
   logic [31:0]   offset_ff, offset_in;

   pse_ctrl_type  ctrl;
   logic          req_acc, rsp_acc, is_last;
   logic [FW-1:0] fill_eff;
   logic [31:0]   cons_eff;
   logic          limited, term, printable, emit;

   logic [Cap-1:0] cell_v;
   logic [6:0]     cell_ch [Cap];

   assign req_acc   = req_tvalid & req_tready;
   assign rsp_acc   = rsp_tvalid & rsp_tready;
   assign csr_ready = 1'b1;

   assign fill_eff  = req_tuser ? '0 : fill_ff;
   assign cons_eff  = req_tuser ? '0 : consumed_ff;
   assign limited   = (scan_limit_ff != '0) && (cons_eff >= scan_limit_ff);
   assign term      = (req_tdata == CHAR_NUL) || (req_tdata == CHAR_NEWLINE)
                      || (fill_eff >= FW'(Cap));
   assign printable = (req_tdata >= CHAR_SPACE) && (req_tdata < CHAR_DEL);
   assign emit      = term && (fill_eff != '0)
                      && (7'(fill_eff) >= {1'b0, min_length_ff});

   always_comb begin
      ctrl.append  = req_acc & ~limited & ~term & printable;
      ctrl.restart = req_acc & req_tuser;
      ctrl.drop    = req_acc & ~limited & ((term & ~emit) | (~term & ~printable));
      ctrl.shift   = rsp_acc;
      ctrl.ch      = req_tdata[6:0];
   end

   always_comb begin
      fill_in      = fill_ff;
      consumed_in  = consumed_ff;
      run_start_in = run_start_ff;
      offset_in    = offset_ff;
      if (req_acc) begin
         fill_in     = fill_eff;
         consumed_in = cons_eff;
         if (!limited) begin
            consumed_in = cons_eff + 32'd1;
            if (term) begin
               fill_in   = '0;
               offset_in = offset_enable_ff ? start_offset_ff + run_start_ff : '0;
            end else if (printable) begin
               fill_in = fill_eff + FW'(1);
               if (fill_eff == '0) begin
                  run_start_in = cons_eff;
               end
            end else begin
               fill_in = '0;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         PSE_IDLE: begin
            if (req_acc && !limited && emit) begin
               state_in = PSE_DRAIN;
            end
         end
         PSE_DRAIN: begin
            if (rsp_acc && is_last) begin
               state_in = PSE_IDLE;
            end
         end
         default: state_in = PSE_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      unique case (state_ff)
         PSE_IDLE:  req_tready = 1'b1;
         PSE_DRAIN: rsp_tvalid = 1'b1;
         default: begin
            req_tready = 1'b0;
            rsp_tvalid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= PSE_IDLE;
         min_length_ff    <= 6'd4;
         start_offset_ff  <= '0;
         scan_limit_ff    <= '0;
         offset_enable_ff <= 1'b0;
         fill_ff          <= '0;
         consumed_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         consumed_ff <= consumed_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN_LENGTH:    min_length_ff    <= csr_data[5:0];
               CSR_START_OFFSET:  start_offset_ff  <= csr_data;
               CSR_SCAN_LIMIT:    scan_limit_ff    <= csr_data;
               CSR_OFFSET_ENABLE: offset_enable_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
      run_start_ff <= run_start_in;
      offset_ff    <= offset_in;
   end

   for (genvar i = 0; i < Cap; i++) begin : g_cell
      logic       prev_v, next_v;
      logic [6:0] next_ch;
      if (i == 0) begin : g_head
         assign prev_v = 1'b1;
      end else begin : g_body
         assign prev_v = cell_v[i-1];
      end
      if (i == Cap - 1) begin : g_tail
         assign next_v  = 1'b0;
         assign next_ch = '0;
      end else begin : g_inner
         assign next_v  = cell_v[i+1];
         assign next_ch = cell_ch[i+1];
      end
      pse_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .prev_v  (prev_v),
         .next_v  (next_v),
         .next_ch (next_ch),
         .cur_v   (cell_v[i]),
         .ch      (cell_ch[i])
      );
   end

   if (Cap > 1) begin : g_last_multi
      assign is_last = ~cell_v[1];
   end else begin : g_last_single
      assign is_last = 1'b1;
   end

   assign rsp_tdata = {1'b0, offset_ff, cell_ch[0]};
   assign rsp_tlast = is_last;

`ifndef SYNTHESIS
   a_drain_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input taken while a run drains");
   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("output continues after last character");
   a_char_printable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[6:5] != 2'b00) && (rsp_tdata[6:0] != 7'h7F))
      else $error("non-printable character emitted");
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> cell_v[0])
      else $error("drain with empty chain head");
`endif

endmodule

>>> rtl/core/pse_cell.sv
// One character cell of the run buffer chain.
// Depends on pse_pkg for the control struct.
module pse_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  pse_pkg::pse_ctrl_type ctrl,
   input  logic                  prev_v,
   input  logic                  next_v,
   input  logic [6:0]            next_ch,
   output logic                  cur_v,
   output logic [6:0]            ch
);
   import pse_pkg::*;

   logic       valid_ff, valid_in;
   logic [6:0] ch_ff, ch_in;
   logic       load;

   assign cur_v = valid_ff & ~ctrl.restart;
   assign load  = ctrl.append & prev_v & ~cur_v;
   assign ch    = ch_ff;

   always_comb begin
      valid_in = cur_v;
      ch_in    = ch_ff;
      priority if (ctrl.shift) begin
         valid_in = next_v;
         ch_in    = next_ch;
      end else if (ctrl.drop) begin
         valid_in = 1'b0;
      end else if (load) begin
         valid_in = 1'b1;
         ch_in    = ctrl.ch;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      ch_ff <= ch_in;
   end

endmodule
